// ===== rtl/rtcsa_pkg.sv =====
// Package for the seconds counter with match alarm.
// Holds the opcodes, register offsets, decoded request type and identification table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rtcsa_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [11:0] OFF_COUNT   = 12'h000;
    localparam logic [11:0] OFF_MATCH   = 12'h004;
    localparam logic [11:0] OFF_LOAD    = 12'h008;
    localparam logic [11:0] OFF_ENABLE  = 12'h00C;
    localparam logic [11:0] OFF_MASK    = 12'h010;
    localparam logic [11:0] OFF_PENDING = 12'h014;
    localparam logic [11:0] OFF_IRQ     = 12'h018;
    localparam logic [11:0] OFF_CLEAR   = 12'h01C;
    localparam logic [6:0]  ID_PAGE     = 7'h7F;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_READ,
        CMD_TICK,
        CMD_WR_MATCH,
        CMD_WR_LOAD,
        CMD_WR_ENABLE,
        CMD_WR_MASK,
        CMD_WR_CLEAR
    } cmd_kind_t;

    typedef enum logic [3:0] {
        RD_ZERO,
        RD_COUNT,
        RD_MATCH,
        RD_LOAD,
        RD_ENABLE,
        RD_MASK,
        RD_PENDING,
        RD_IRQ,
        RD_ID
    } rd_sel_t;

    typedef struct packed {
        cmd_kind_t   kind;
        rd_sel_t     rsel;
        logic [7:0]  id_byte;
        logic [31:0] wdata;
    } cmd_t;

    function automatic logic [7:0] id_lookup(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'h31;
            3'd1: b = 8'h10;
            3'd2: b = 8'h04;
            3'd3: b = 8'h00;
            3'd4: b = 8'h0D;
            3'd5: b = 8'hF0;
            3'd6: b = 8'h05;
            3'd7: b = 8'hB1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rtc_seconds_alarm_regs.sv =====
// Throughput: one request per cycle while the queue is not full; the back end retires
// one queued request per cycle while the output register is empty or being taken.
// The queue between front and back ends decouples input stalls from output stalls.
// Reset: synchronous, active low; counter, match and load clear, counting enabled,
// mask, pending and armed flags clear, queue and output register emptied.
// Top level of the seconds counter with match alarm; uses rtcsa_pkg and its submodules.
`default_nettype none

module rtc_seconds_alarm_regs #(
    parameter int unsigned QUEUE_DEPTH = rtcsa_pkg::QUEUE_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_opcode,
    input  wire logic [11:0]  s_reg_offset,
    input  wire logic [3:0]   s_access_size,
    input  wire logic [31:0]  s_write_value,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [31:0]       m_read_data,
    output logic              m_irq_line
);

    rtcsa_pkg::cmd_t front_cmd;
    rtcsa_pkg::cmd_t head_cmd;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_valid;

    rtcsa_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_reg_offset  (s_reg_offset),
        .s_access_size (s_access_size),
        .s_write_value (s_write_value),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (front_cmd)
    );

    rtcsa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .head_cmd (head_cmd)
    );

    rtcsa_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .head_cmd    (head_cmd),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data),
        .m_irq_line  (m_irq_line)
    );

endmodule

`default_nettype wire

// ===== rtl/rtcsa_front.sv =====
// Front end: takes requests from the input channel and classifies them.
// Produces a decoded request for the queue; uses rtcsa_pkg.
`default_nettype none

module rtcsa_front (
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_opcode,
    input  wire logic [11:0]         s_reg_offset,
    input  wire logic [3:0]          s_access_size,
    input  wire logic [31:0]         s_write_value,
    input  wire logic                q_full,
    output logic                     q_push,
    output rtcsa_pkg::cmd_t          q_cmd
);

    logic size_ok;
    logic id_hit;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign size_ok = (s_access_size == 4'd1) || (s_access_size == 4'd2) ||
                     (s_access_size == 4'd4) || (s_access_size == 4'd8);
    assign id_hit  = (s_reg_offset[11:5] == rtcsa_pkg::ID_PAGE) &&
                     (s_reg_offset[1:0] == 2'b00);

    always_comb begin
        q_cmd.kind    = rtcsa_pkg::CMD_NOP;
        q_cmd.rsel    = rtcsa_pkg::RD_ZERO;
        q_cmd.id_byte = rtcsa_pkg::id_lookup(s_reg_offset[4:2]);
        q_cmd.wdata   = s_write_value;
        priority if (s_opcode == rtcsa_pkg::OP_TICK) begin
            q_cmd.kind = rtcsa_pkg::CMD_TICK;
        end else if (s_opcode == rtcsa_pkg::OP_READ && size_ok) begin
            q_cmd.kind = rtcsa_pkg::CMD_READ;
            if (id_hit) begin
                q_cmd.rsel = rtcsa_pkg::RD_ID;
            end else begin
                case (s_reg_offset)
                    rtcsa_pkg::OFF_COUNT:   q_cmd.rsel = rtcsa_pkg::RD_COUNT;
                    rtcsa_pkg::OFF_MATCH:   q_cmd.rsel = rtcsa_pkg::RD_MATCH;
                    rtcsa_pkg::OFF_LOAD:    q_cmd.rsel = rtcsa_pkg::RD_LOAD;
                    rtcsa_pkg::OFF_ENABLE:  q_cmd.rsel = rtcsa_pkg::RD_ENABLE;
                    rtcsa_pkg::OFF_MASK:    q_cmd.rsel = rtcsa_pkg::RD_MASK;
                    rtcsa_pkg::OFF_PENDING: q_cmd.rsel = rtcsa_pkg::RD_PENDING;
                    rtcsa_pkg::OFF_IRQ:     q_cmd.rsel = rtcsa_pkg::RD_IRQ;
                    default:                q_cmd.rsel = rtcsa_pkg::RD_ZERO;
                endcase
            end
        end else if (s_opcode == rtcsa_pkg::OP_WRITE && size_ok) begin
            case (s_reg_offset)
                rtcsa_pkg::OFF_MATCH:  q_cmd.kind = rtcsa_pkg::CMD_WR_MATCH;
                rtcsa_pkg::OFF_LOAD:   q_cmd.kind = rtcsa_pkg::CMD_WR_LOAD;
                rtcsa_pkg::OFF_ENABLE: q_cmd.kind = rtcsa_pkg::CMD_WR_ENABLE;
                rtcsa_pkg::OFF_MASK:   q_cmd.kind = rtcsa_pkg::CMD_WR_MASK;
                rtcsa_pkg::OFF_CLEAR:  q_cmd.kind = rtcsa_pkg::CMD_WR_CLEAR;
                default:               q_cmd.kind = rtcsa_pkg::CMD_NOP;
            endcase
        end else begin
            q_cmd.kind = rtcsa_pkg::CMD_NOP;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rtcsa_queue.sv =====
// Short request queue between the front end and the back end.
// Stores decoded requests of type rtcsa_pkg::cmd_t.
`default_nettype none

module rtcsa_queue #(
    parameter int unsigned DEPTH = rtcsa_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire rtcsa_pkg::cmd_t push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 q_valid,
    output rtcsa_pkg::cmd_t      head_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rtcsa_pkg::cmd_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_pop   = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into a full queue");

endmodule

`default_nettype wire

// ===== rtl/rtcsa_back.sv =====
// Back end: holds the clock and alarm registers and carries out decoded requests.
// Drives the result channel from an output register; uses rtcsa_pkg.
`default_nettype none

module rtcsa_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire rtcsa_pkg::cmd_t head_cmd,
    output logic                 pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [31:0]          m_read_data,
    output logic                 m_irq_line
);

    logic [31:0] count_reg, count_next;
    logic [31:0] match_reg, match_next;
    logic [31:0] load_reg, load_next;
    logic        enable_reg, enable_next;
    logic        mask_reg, mask_next;
    logic        pending_reg, pending_next;
    logic        armed_reg, armed_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;
    logic        m_irq_reg, m_irq_next;
    logic        do_check;
    logic [31:0] rdata;

    assign pop         = q_valid && (!m_valid_reg || m_ready);
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;
    assign m_irq_line  = m_irq_reg;

    always_comb begin
        count_next   = count_reg;
        match_next   = match_reg;
        load_next    = load_reg;
        enable_next  = enable_reg;
        mask_next    = mask_reg;
        pending_next = pending_reg;
        armed_next   = armed_reg;
        do_check     = 1'b0;
        unique case (head_cmd.kind)
            rtcsa_pkg::CMD_NOP: begin
            end
            rtcsa_pkg::CMD_READ: begin
                do_check = 1'b1;
            end
            rtcsa_pkg::CMD_TICK: begin
                if (enable_reg) begin
                    count_next = count_reg + 32'd1;
                    do_check   = 1'b1;
                end
            end
            rtcsa_pkg::CMD_WR_MATCH: begin
                match_next   = head_cmd.wdata;
                pending_next = 1'b0;
                armed_next   = 1'b1;
                do_check     = 1'b1;
            end
            rtcsa_pkg::CMD_WR_LOAD: begin
                load_next  = head_cmd.wdata;
                count_next = head_cmd.wdata;
                do_check   = 1'b1;
            end
            rtcsa_pkg::CMD_WR_ENABLE: begin
                enable_next = head_cmd.wdata[0];
                do_check    = 1'b1;
            end
            rtcsa_pkg::CMD_WR_MASK: begin
                mask_next = head_cmd.wdata[0];
            end
            rtcsa_pkg::CMD_WR_CLEAR: begin
                pending_next = 1'b0;
                armed_next   = 1'b0;
            end
            default: begin
            end
        endcase
        if (do_check && !pending_next && armed_next && enable_next &&
            (count_next >= match_next)) begin
            pending_next = 1'b1;
            armed_next   = 1'b0;
        end
    end

    always_comb begin
        unique case (head_cmd.rsel)
            rtcsa_pkg::RD_ZERO:    rdata = '0;
            rtcsa_pkg::RD_COUNT:   rdata = count_next;
            rtcsa_pkg::RD_MATCH:   rdata = match_next;
            rtcsa_pkg::RD_LOAD:    rdata = load_next;
            rtcsa_pkg::RD_ENABLE:  rdata = {31'd0, enable_next};
            rtcsa_pkg::RD_MASK:    rdata = {31'd0, mask_next};
            rtcsa_pkg::RD_PENDING: rdata = {31'd0, pending_next};
            rtcsa_pkg::RD_IRQ:     rdata = {31'd0, pending_next & mask_next};
            rtcsa_pkg::RD_ID:      rdata = {24'd0, head_cmd.id_byte};
            default:               rdata = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_irq_next   = m_irq_reg;
        if (pop) begin
            m_valid_next = 1'b1;
            m_data_next  = (head_cmd.kind == rtcsa_pkg::CMD_READ) ? rdata : 32'd0;
            m_irq_next   = pending_next & mask_next;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            match_reg   <= '0;
            load_reg    <= '0;
            enable_reg  <= 1'b1;
            mask_reg    <= 1'b0;
            pending_reg <= 1'b0;
            armed_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                count_reg   <= count_next;
                match_reg   <= match_next;
                load_reg    <= load_next;
                enable_reg  <= enable_next;
                mask_reg    <= mask_next;
                pending_reg <= pending_next;
                armed_reg   <= armed_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_irq_reg  <= m_irq_next;
    end

    a_pend_arm_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pending_reg && armed_reg))
        else $error("alarm pending and armed together");
    a_irq_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_irq_reg == (pending_reg & mask_reg)))
        else $error("interrupt output out of step with alarm state");
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$past(pop)) |-> ($stable(count_reg) && $stable(match_reg)))
        else $error("clock state changed without a request");

endmodule

`default_nettype wire

// ===== tb/rtc_alarm_checker.sv =====
// Checker for the seconds counter with match alarm: watches both channels,
// keeps its own copy of the clock and alarm state, and compares every result.
// Depends on rtcsa_pkg for opcodes and register offsets.
module rtc_alarm_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [11:0] s_reg_offset,
    input  wire logic [3:0]  s_access_size,
    input  wire logic [31:0] s_write_value,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_read_data,
    input  wire logic        m_irq_line,
    output int               fail_count,
    output int               awaiting
);

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
    } rtc_result_t;

    rtc_result_t expected_results[$];

    logic [31:0] sec_count;
    logic [31:0] match_reg;
    logic [31:0] load_reg;
    logic        en_bit;
    logic        mask_bit;
    logic        pend_bit;
    logic        armed_bit;
    int          mismatches = 0;

    function automatic logic size_valid(input logic [3:0] sz);
        return sz inside {4'd1, 4'd2, 4'd4, 4'd8};
    endfunction

    function automatic logic [31:0] reg_value(input logic [11:0] off);
        logic [31:0] v;
        v = '0;
        case (off)
            rtcsa_pkg::OFF_COUNT:   v = sec_count;
            rtcsa_pkg::OFF_MATCH:   v = match_reg;
            rtcsa_pkg::OFF_LOAD:    v = load_reg;
            rtcsa_pkg::OFF_ENABLE:  v = {31'd0, en_bit};
            rtcsa_pkg::OFF_MASK:    v = {31'd0, mask_bit};
            rtcsa_pkg::OFF_PENDING: v = {31'd0, pend_bit};
            rtcsa_pkg::OFF_IRQ:     v = {31'd0, pend_bit & mask_bit};
            default: begin
                if (off[11:5] == rtcsa_pkg::ID_PAGE && off[1:0] == 2'b00) begin
                    case (off[4:2])
                        3'd0: v = 32'h31;
                        3'd1: v = 32'h10;
                        3'd2: v = 32'h04;
                        3'd3: v = 32'h00;
                        3'd4: v = 32'h0D;
                        3'd5: v = 32'hF0;
                        3'd6: v = 32'h05;
                        default: v = 32'hB1;
                    endcase
                end
            end
        endcase
        return v;
    endfunction

    task automatic eval_alarm();
        if (!pend_bit && armed_bit && en_bit && sec_count >= match_reg) begin
            pend_bit = 1'b1;
            armed_bit = 1'b0;
        end
    endtask

    task automatic predict_request(input logic [1:0] op, input logic [11:0] off,
                                   input logic [3:0] sz, input logic [31:0] val,
                                   output rtc_result_t res);
        logic [31:0] rd;
        rd = '0;
        if (op == rtcsa_pkg::OP_READ && size_valid(sz)) begin
            eval_alarm();
            rd = reg_value(off);
        end else if (op == rtcsa_pkg::OP_WRITE && size_valid(sz)) begin
            case (off)
                rtcsa_pkg::OFF_MATCH: begin
                    match_reg = val;
                    pend_bit = 1'b0;
                    armed_bit = 1'b1;
                    eval_alarm();
                end
                rtcsa_pkg::OFF_LOAD: begin
                    load_reg = val;
                    sec_count = val;
                    eval_alarm();
                end
                rtcsa_pkg::OFF_ENABLE: begin
                    en_bit = val[0];
                    eval_alarm();
                end
                rtcsa_pkg::OFF_MASK: mask_bit = val[0];
                rtcsa_pkg::OFF_CLEAR: begin
                    pend_bit = 1'b0;
                    armed_bit = 1'b0;
                end
                default: ;
            endcase
        end else if (op == rtcsa_pkg::OP_TICK && en_bit) begin
            sec_count = sec_count + 32'd1;
            eval_alarm();
        end
        res.read_data = rd;
        res.irq_line = pend_bit & mask_bit;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("rtc check: %s expected %08h got %08h", what, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        rtc_result_t want;
        rtc_result_t fresh;
        if (!aresetn) begin
            sec_count = '0;
            match_reg = '0;
            load_reg = '0;
            en_bit = 1'b1;
            mask_bit = 1'b0;
            pend_bit = 1'b0;
            armed_bit = 1'b0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unrequested result, read_data", '0, m_read_data);
                end else begin
                    want = expected_results.pop_front();
                    if (m_read_data !== want.read_data)
                        report_mismatch("read_data", want.read_data, m_read_data);
                    if (m_irq_line !== want.irq_line)
                        report_mismatch("irq_line", {31'd0, want.irq_line},
                                        {31'd0, m_irq_line});
                end
            end
            if (s_valid && s_ready) begin
                predict_request(s_opcode, s_reg_offset, s_access_size, s_write_value,
                                fresh);
                expected_results.push_back(fresh);
            end
        end
        fail_count <= mismatches;
        awaiting <= expected_results.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the testbench for the seconds counter with match alarm: clock, reset,
// request stimulus over several idling phases, and the final verdict.
// Depends on rtcsa_pkg, rtc_seconds_alarm_regs and rtc_alarm_checker.
module tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [11:0] ID_BASE = {rtcsa_pkg::ID_PAGE, 5'd0};
    localparam int PHASE_ITEMS = 288;
    localparam int HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = '0;
    logic [11:0] s_reg_offset = '0;
    logic [3:0]  s_access_size = '0;
    logic [31:0] s_write_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_data;
    logic        m_irq_line;

    int          fail_count;
    int          awaiting;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_seq = 0;
    int          hold_seen = 0;
    logic [31:0] approx_count = '0;

    rtc_seconds_alarm_regs dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_reg_offset  (s_reg_offset),
        .s_access_size (s_access_size),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_irq_line    (m_irq_line)
    );

    rtc_alarm_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_reg_offset  (s_reg_offset),
        .s_access_size (s_access_size),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_irq_line    (m_irq_line),
        .fail_count    (fail_count),
        .awaiting      (awaiting)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

    // The receiver stalls at random, and holds off for a long stretch whenever
    // the stimulus asks for one.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [11:0] off,
                                input logic [3:0] sz, input logic [31:0] val);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_reg_offset <= off;
        s_access_size <= sz;
        s_write_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [11:0] known_offset(input int idx);
        logic [11:0] off;
        case (idx)
            0: off = rtcsa_pkg::OFF_COUNT;
            1: off = rtcsa_pkg::OFF_MATCH;
            2: off = rtcsa_pkg::OFF_LOAD;
            3: off = rtcsa_pkg::OFF_ENABLE;
            4: off = rtcsa_pkg::OFF_MASK;
            5: off = rtcsa_pkg::OFF_PENDING;
            6: off = rtcsa_pkg::OFF_IRQ;
            7: off = rtcsa_pkg::OFF_CLEAR;
            default: off = ID_BASE | 12'((idx - 8) * 4);
        endcase
        return off;
    endfunction

    task automatic send_random_request();
        int          pick;
        logic [31:0] v;
        logic [3:0]  sz;
        pick = $urandom_range(99);
        sz = 4'(1 << $urandom_range(3));
        v = $urandom();
        if (pick < 34) begin
            send_request(rtcsa_pkg::OP_TICK, 12'($urandom_range(4095)),
                         4'($urandom_range(15)), v);
            approx_count = approx_count + 32'd1;
        end else if (pick < 54) begin
            send_request(rtcsa_pkg::OP_READ, known_offset($urandom_range(15)), sz, v);
        end else if (pick < 64) begin
            if ($urandom_range(9) < 7)
                v = approx_count + 32'($urandom_range(10)) - 32'd2;
            send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_MATCH, sz, v);
        end else if (pick < 71) begin
            case ($urandom_range(2))
                0: v = 32'($urandom_range(20));
                1: v = 32'hFFFFFFF0 + 32'($urandom_range(15));
                default: ;
            endcase
            approx_count = v;
            send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_LOAD, sz, v);
        end else if (pick < 76) begin
            v[0] = ($urandom_range(9) != 0);
            send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_ENABLE, sz, v);
        end else if (pick < 81) begin
            send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_MASK, sz, v);
        end else if (pick < 85) begin
            send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_CLEAR, sz, v);
        end else if (pick < 89) begin
            send_request(rtcsa_pkg::OP_WRITE, known_offset($urandom_range(15)), sz, v);
        end else begin
            send_request(2'($urandom_range(3)), 12'($urandom_range(4095)),
                         4'($urandom_range(15)), v);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(rtcsa_pkg::OP_READ, rtcsa_pkg::OFF_COUNT, 4'd4, 32'h0);
        send_request(rtcsa_pkg::OP_READ, rtcsa_pkg::OFF_ENABLE, 4'd1, 32'h0);
        send_request(rtcsa_pkg::OP_READ, ID_BASE, 4'd4, 32'h0);
        send_request(rtcsa_pkg::OP_READ, ID_BASE | 12'h00C, 4'd2, 32'h0);
        send_request(rtcsa_pkg::OP_READ, ID_BASE | 12'h01C, 4'd8, 32'h0);
        send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_MASK, 4'd4, 32'hFFFFFFFF);
        send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_LOAD, 4'd4, 32'hFFFFFFFE);
        send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_MATCH, 4'd4, 32'hFFFFFFFF);
        send_request(rtcsa_pkg::OP_TICK, 12'h000, 4'd0, 32'h0);
        send_request(rtcsa_pkg::OP_READ, rtcsa_pkg::OFF_PENDING, 4'd4, 32'h0);
        send_request(rtcsa_pkg::OP_READ, rtcsa_pkg::OFF_IRQ, 4'd4, 32'h0);
        send_request(rtcsa_pkg::OP_TICK, 12'hFFF, 4'd15, 32'hFFFFFFFF);
        send_request(rtcsa_pkg::OP_READ, rtcsa_pkg::OFF_COUNT, 4'd4, 32'h0);
        send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_CLEAR, 4'd4, 32'h0);
        send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_ENABLE, 4'd4, 32'hFFFFFFFE);
        send_request(rtcsa_pkg::OP_TICK, 12'h000, 4'd4, 32'h0);
        send_request(rtcsa_pkg::OP_READ, rtcsa_pkg::OFF_COUNT, 4'd4, 32'h0);
        send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_ENABLE, 4'd4, 32'h00000001);
        send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_MATCH, 4'd4, 32'h0);
        send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_CLEAR, 4'd1, 32'h0);
        send_request(rtcsa_pkg::OP_READ, rtcsa_pkg::OFF_MATCH, 4'd3, 32'h0);
        send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_LOAD, 4'd0, 32'hFFFFFFFF);
        send_request(rtcsa_pkg::OP_READ, 12'h002, 4'd4, 32'h0);
        send_request(OP_UNUSED, rtcsa_pkg::OFF_LOAD, 4'd4, 32'h12345678);
        send_request(rtcsa_pkg::OP_READ, 12'hFFF, 4'd8, 32'h0);
        approx_count = '0;
        send_request(rtcsa_pkg::OP_WRITE, rtcsa_pkg::OFF_LOAD, 4'd8, 32'h0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_seq <= hold_seq + 1;
                end
                1: begin
                    send_idle_pct = 79;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 79;
                end
                default: begin
                    send_idle_pct = 9;
                    recv_stall_pct = 9;
                end
            endcase
            repeat (PHASE_ITEMS) send_random_request();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && awaiting == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
